@@ hdl/ocep_pkg.sv @@
package ocep_pkg;

    localparam int CORDIC_ITER_DEF = 16;
    localparam int ANGLE_FRAC_DEF  = 16;

    // Datapath widths of the rotator: x and y in Q30 with headroom, z in Q30 over 2pi
    localparam int XW = 34;
    localparam int ZW = 36;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint MILLI_Q30   = 64'sd1073742;
    localparam longint GAIN_Q30    = 64'sd652032874;

    localparam int RADIUS_W = 23;
    localparam int COORD_W  = 24;
    localparam int AMOUNT_W = 24;

    typedef enum logic [1:0] {
        CMD_ROT_AZ   = 2'd0,
        CMD_ROT_POL  = 2'd1,
        CMD_ZOOM     = 2'd2,
        CMD_RESTART  = 2'd3
    } cmd_t;

    localparam logic [2:0] REG_CENTER_X     = 3'd0;
    localparam logic [2:0] REG_CENTER_Y     = 3'd1;
    localparam logic [2:0] REG_CENTER_Z     = 3'd2;
    localparam logic [2:0] REG_MIN_RADIUS   = 3'd3;
    localparam logic [2:0] REG_START_RADIUS = 3'd4;
    localparam logic [2:0] REG_START_AZ     = 3'd5;
    localparam logic [2:0] REG_START_POLAR  = 3'd6;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WRAP = 6'b000010,
        ST_FEED = 6'b000100,
        ST_WAIT = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic                 tag;
        logic                 neg;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    function automatic longint two_pi_f(int f);
        int sh;
        sh = 30 - f;
        return (2 * PI_Q30 + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint cap_f(int f);
        int sh;
        sh = 30 - f;
        return (HALF_PI_Q30 - MILLI_Q30 + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [XW-1:0] atan_q30(int i);
        logic signed [XW-1:0] v;
        case (i)
            0:       v = 34'sd843314856;
            1:       v = 34'sd497837829;
            2:       v = 34'sd263043836;
            3:       v = 34'sd133525158;
            4:       v = 34'sd67021686;
            5:       v = 34'sd33543515;
            6:       v = 34'sd16775850;
            7:       v = 34'sd8388437;
            8:       v = 34'sd4194282;
            9:       v = 34'sd2097149;
            10:      v = 34'sd1048575;
            11:      v = 34'sd524287;
            12:      v = 34'sd262143;
            13:      v = 34'sd131071;
            14:      v = 34'sd65535;
            15:      v = 34'sd32767;
            16:      v = 34'sd16383;
            17:      v = 34'sd8191;
            18:      v = 34'sd4095;
            19:      v = 34'sd2047;
            20:      v = 34'sd1023;
            21:      v = 34'sd511;
            22:      v = 34'sd255;
            23:      v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a Q30 product half up and drop the fraction
    function automatic logic signed [2*XW-1:0] round_q30(logic signed [2*XW-1:0] p);
        return (p + (68'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(logic signed [2*XW-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > 68'sd8388607) begin
            r = 24'h7fffff;
        end else if (v < -68'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/orbit_camera_eye_position_core.sv @@
// Orbit camera eye position core.
// Input stream: s_tuser carries the command (rotate azimuth, rotate polar,
// zoom, restart), s_tdata the signed amount. Each transaction yields exactly
// one output transaction holding the saturated eye x/y/z and the updated
// azimuth, polar angle and radius.
// Configuration (center, minimum radius, restart pose) is to be written over
// the APB port only while the core is idle; the core itself does not enforce
// this. Reads return the stored values. One command is processed at a time.
// Azimuth and restart commands first reduce the azimuth modulo 2pi in three
// steps (reciprocal quotient estimate, subtract, one correction); polar and
// zoom commands go straight to the CORDIC row. The next command can be
// accepted as soon as m_tvalid rises.
// The sine and cosine come from a row of CORDIC cells, one rotation per cell;
// the five products then share one multiplier, one per cycle.
// A finished result sits in the output register; the next command can be
// accepted while it waits, and the core holds before overwriting it until
// m_tready takes it.
// Reset clears azimuth, polar and radius to zero, so the eye equals the center
// until a restart or zoom command; configuration registers take their defaults.
module orbit_camera_eye_position_core #(
    parameter int CORDIC_ITERATIONS = ocep_pkg::CORDIC_ITER_DEF,
    parameter int ANGLE_FRAC_BITS   = ocep_pkg::ANGLE_FRAC_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [23:0] amount
    input  logic [1:0]   s_tuser,   // [1:0] command
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] eye_x, [47:24] eye_y, [71:48] eye_z, [90:72] azimuth_now,
    // [108:91] polar_now, [131:109] radius_now, [135:132] zero
    output logic [135:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ocep_pkg::*;

    localparam int AZW   = ANGLE_FRAC_BITS + 3;
    localparam int PW    = ANGLE_FRAC_BITS + 2;
    localparam int SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int RW    = 26;
    localparam int QW    = RW + 18 - 32;
    localparam logic [RW-1:0] TWO_PI = RW'(two_pi_f(ANGLE_FRAC_BITS));
    localparam logic [17:0] RECIP = 18'((64'sd1 <<< 32) / two_pi_f(ANGLE_FRAC_BITS));
    localparam logic signed [24:0] CAP = 25'(cap_f(ANGLE_FRAC_BITS));
    localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI_Q30);
    localparam logic signed [ZW-1:0] TWOPI_Z = ZW'(2 * PI_Q30);
    localparam logic signed [ZW-1:0] HPI_Z   = ZW'(HALF_PI_Q30);

    // configuration
    logic [23:0] cx_reg, cy_reg, cz_reg;
    logic [22:0] min_rad_reg, start_rad_reg;
    logic [18:0] start_az_reg;
    logic [17:0] start_pol_reg;

    // camera state
    state_t                state_reg;
    logic [AZW-1:0]        az_reg;
    logic signed [PW-1:0]  pol_reg;
    logic [RADIUS_W-1:0]   rad_reg;

    logic [RW-1:0]         rem_reg;
    logic                  rem_neg_reg;
    logic [QW-1:0]         quot_reg;
    logic [1:0]            k_reg;
    logic                  feed_reg;
    logic [2:0]            mstep_reg;

    logic signed [XW-1:0]  ca_reg, sa_reg, cp_reg, sp_reg;
    logic signed [XW-1:0]  cpca_reg, cpsa_reg;
    logic signed [2*XW-1:0] prod_reg;
    logic [COORD_W-1:0]    ex_reg, ey_reg, ez_reg;
    logic                  m_tvalid_reg;
    logic [135:0]          m_tdata_reg;

    // APB
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            min_rad_reg   <= 23'd256;
            start_rad_reg <= 23'd2560;
            start_az_reg  <= '0;
            start_pol_reg <= '0;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_CENTER_X:     cx_reg        <= pwdata[23:0];
                REG_CENTER_Y:     cy_reg        <= pwdata[23:0];
                REG_CENTER_Z:     cz_reg        <= pwdata[23:0];
                REG_MIN_RADIUS:   min_rad_reg   <= pwdata[22:0];
                REG_START_RADIUS: start_rad_reg <= pwdata[22:0];
                REG_START_AZ:     start_az_reg  <= pwdata[18:0];
                REG_START_POLAR:  start_pol_reg <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CENTER_X:     prdata = {8'd0, cx_reg};
            REG_CENTER_Y:     prdata = {8'd0, cy_reg};
            REG_CENTER_Z:     prdata = {8'd0, cz_reg};
            REG_MIN_RADIUS:   prdata = {9'd0, min_rad_reg};
            REG_START_RADIUS: prdata = {9'd0, start_rad_reg};
            REG_START_AZ:     prdata = {13'd0, start_az_reg};
            REG_START_POLAR:  prdata = {14'd0, start_pol_reg};
            default:          prdata = '0;
        endcase
    end

    // command decode
    logic signed [AMOUNT_W-1:0] amt;
    logic signed [RW-1:0]       az_sum;
    logic signed [24:0]         pol_sum, pol_start, pol_clamp_in, pol_clamped;
    logic signed [RW-1:0]       zoom_diff;
    logic [RADIUS_W-1:0]        zoom_next;
    logic                       s_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign amt      = $signed(s_tdata);

    always_comb begin
        az_sum    = $signed(RW'(az_reg)) + RW'(amt);
        pol_sum   = 25'(pol_reg) + 25'(amt);
        pol_start = 25'($signed(start_pol_reg));
        pol_clamp_in = (cmd_t'(s_tuser) == CMD_RESTART) ? pol_start : pol_sum;
        if (pol_clamp_in > CAP) begin
            pol_clamped = CAP;
        end else if (pol_clamp_in < -CAP) begin
            pol_clamped = -CAP;
        end else begin
            pol_clamped = pol_clamp_in;
        end
        zoom_diff = $signed(RW'(rad_reg)) - RW'(amt);
        if (zoom_diff > 26'sd8388607) begin
            zoom_next = 23'h7fffff;
        end else if (zoom_diff < $signed(RW'(min_rad_reg))) begin
            zoom_next = min_rad_reg;
        end else begin
            zoom_next = zoom_diff[RADIUS_W-1:0];
        end
    end

    // modulo 2pi: estimate the quotient by reciprocal multiply (low by at most
    // one), subtract the multiple, then fix up with one compare and subtract
    logic [RW+17:0] recip_prod;
    logic [RW-1:0]  quot_mul;
    logic [RW-1:0]  rem_fix;
    assign recip_prod = rem_reg * RECIP;
    assign quot_mul   = RW'(quot_reg) * TWO_PI;
    assign rem_fix    = (rem_reg >= TWO_PI) ? rem_reg - TWO_PI : rem_reg;

    // CORDIC row
    cordic_t chain [CORDIC_ITERATIONS+1];
    logic signed [ZW-1:0] z_raw, z_wrap;

    always_comb begin
        if (!feed_reg) begin
            z_raw = $signed(ZW'(az_reg)) <<< SHIFT;
        end else begin
            z_raw = ZW'(pol_reg) <<< SHIFT;
        end
        z_wrap = z_raw;
        if (z_raw > PI_Z) begin
            z_wrap = z_raw - TWOPI_Z;
        end else if (z_raw < -PI_Z) begin
            z_wrap = z_raw + TWOPI_Z;
        end
        chain[0].valid = (state_reg == ST_FEED);
        chain[0].tag   = feed_reg;
        chain[0].x     = XW'(GAIN_Q30);
        chain[0].y     = '0;
        // fold into [-pi/2, pi/2] and flip both results afterwards
        if (z_wrap > HPI_Z) begin
            chain[0].z   = z_wrap - PI_Z;
            chain[0].neg = 1'b1;
        end else if (z_wrap < -HPI_Z) begin
            chain[0].z   = z_wrap + PI_Z;
            chain[0].neg = 1'b1;
        end else begin
            chain[0].z   = z_wrap;
            chain[0].neg = 1'b0;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
        ocep_cell #(.IDX(i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cell_in (chain[i]),
            .cell_out(chain[i+1])
        );
    end

    cordic_t              tail;
    logic signed [XW-1:0] cos_out, sin_out;
    assign tail    = chain[CORDIC_ITERATIONS];
    assign cos_out = tail.neg ? -tail.x : tail.x;
    assign sin_out = tail.neg ? -tail.y : tail.y;

    // shared multiplier
    logic signed [XW-1:0]    mul_a, mul_b, rad_s;
    logic signed [2*XW-1:0]  prod_rnd, eye_sum;
    logic signed [COORD_W-1:0] ctr;

    assign rad_s    = $signed(XW'(rad_reg));
    assign prod_rnd = round_q30(prod_reg);

    always_comb begin
        case (mstep_reg)
            3'd0:    begin mul_a = cp_reg; mul_b = ca_reg;   end
            3'd1:    begin mul_a = cp_reg; mul_b = sa_reg;   end
            3'd2:    begin mul_a = rad_s;  mul_b = cpca_reg; end
            3'd3:    begin mul_a = rad_s;  mul_b = sp_reg;   end
            default: begin mul_a = rad_s;  mul_b = cpsa_reg; end
        endcase
        case (mstep_reg)
            3'd3:    ctr = $signed(cx_reg);
            3'd4:    ctr = $signed(cy_reg);
            default: ctr = $signed(cz_reg);
        endcase
        eye_sum = prod_rnd + (2*XW)'(ctr);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_MUL) begin
            case (mstep_reg)
                3'd1:    cpca_reg <= prod_rnd[XW-1:0];
                3'd2:    cpsa_reg <= prod_rnd[XW-1:0];
                3'd3:    ex_reg   <= sat_coord(eye_sum);
                3'd4:    ey_reg   <= sat_coord(eye_sum);
                3'd5:    ez_reg   <= sat_coord(eye_sum);
                default: ;
            endcase
        end
        if (tail.valid && !tail.tag) begin
            ca_reg <= cos_out;
            sa_reg <= sin_out;
        end
        if (tail.valid && tail.tag) begin
            cp_reg <= cos_out;
            sp_reg <= sin_out;
        end
    end

    // sequencer
    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            az_reg       <= '0;
            pol_reg      <= '0;
            rad_reg      <= '0;
            feed_reg     <= 1'b0;
            mstep_reg    <= '0;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    feed_reg <= 1'b0;
                    if (s_fire) begin
                        k_reg <= 2'd2;
                        case (cmd_t'(s_tuser))
                            CMD_ROT_AZ: begin
                                rem_reg     <= az_sum[RW-1] ? RW'(-az_sum) : RW'(az_sum);
                                rem_neg_reg <= az_sum[RW-1];
                                state_reg   <= ST_WRAP;
                            end
                            CMD_ROT_POL: begin
                                pol_reg   <= PW'(pol_clamped);
                                state_reg <= ST_FEED;
                            end
                            CMD_ZOOM: begin
                                rad_reg   <= zoom_next;
                                state_reg <= ST_FEED;
                            end
                            default: begin
                                rem_reg     <= RW'(start_az_reg);
                                rem_neg_reg <= 1'b0;
                                pol_reg     <= PW'(pol_clamped);
                                rad_reg     <= start_rad_reg;
                                state_reg   <= ST_WRAP;
                            end
                        endcase
                    end
                end
                ST_WRAP: begin
                    k_reg <= k_reg - 2'd1;
                    case (k_reg)
                        2'd2: quot_reg <= recip_prod[RW+17:32];
                        2'd1: rem_reg  <= rem_reg - quot_mul;
                        default: begin
                            az_reg <= (rem_neg_reg && rem_fix != '0) ?
                                      AZW'(TWO_PI - rem_fix) : AZW'(rem_fix);
                            state_reg <= ST_FEED;
                        end
                    endcase
                end
                ST_FEED: begin
                    feed_reg <= 1'b1;
                    if (feed_reg) begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    mstep_reg <= '0;
                    if (tail.valid && tail.tag) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd5) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the previous result is taken
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, rad_reg, 18'(pol_reg), 19'(az_reg),
                                         ez_reg, ey_reg, ex_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hdl/ocep_cell.sv @@
module ocep_cell #(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ocep_pkg::cordic_t cell_in,
    output ocep_pkg::cordic_t cell_out
);
    import ocep_pkg::*;

    localparam logic signed [XW-1:0] ATAN = atan_q30(IDX);

    cordic_t cell_reg;
    cordic_t cell_next;
    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;

    always_comb begin
        x_sh = $signed(cell_in.x) >>> IDX;
        y_sh = $signed(cell_in.y) >>> IDX;
        cell_next = cell_in;
        if (!cell_in.z[ZW-1]) begin
            cell_next.x = cell_in.x - y_sh;
            cell_next.y = cell_in.y + x_sh;
            cell_next.z = cell_in.z - ZW'(ATAN);
        end else begin
            cell_next.x = cell_in.x + y_sh;
            cell_next.y = cell_in.y - x_sh;
            cell_next.z = cell_in.z + ZW'(ATAN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

@@ sim/tb_orbit_camera_eye_position_core.sv @@
`timescale 1ns / 1ps

module tb_orbit_camera_eye_position_core;
    import ocep_pkg::*;

    localparam longint TWO_PI_A = 411775;
    localparam longint CAP_A    = 102878;
    localparam int     N_ROT    = 16;
    localparam int     WATCHDOG = 20000;

    typedef struct packed {
        logic [22:0] radius;
        logic [17:0] polar;
        logic [18:0] azimuth;
        logic [23:0] eye_z;
        logic [23:0] eye_y;
        logic [23:0] eye_x;
    } eye_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    orbit_camera_eye_position_core dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // camera state and register copies
    longint      cam_az, cam_pol, cam_rad;
    logic [31:0] regs [7];
    eye_result_t eye_queue [$];
    int          n_err = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sx(longint v, int w);
        longint m;
        m = (64'sd1 <<< w) - 1;
        v = v & m;
        if (v[w-1]) v = v - (64'sd1 <<< w);
        return v;
    endfunction

    function automatic longint wrap_angle(longint v);
        v = v % TWO_PI_A;
        if (v < 0) v += TWO_PI_A;
        return v;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic rotate_sincos(input longint ang, output longint sn, output longint cs);
        longint z, x, y, nx;
        longint atab [16];
        bit     flip;
        atab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                 262143, 131071, 65535, 32767};
        z = ang * 16384;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (z > PI_Q30) z -= 2 * PI_Q30;
        if (z < -PI_Q30) z += 2 * PI_Q30;
        if (z > HALF_PI_Q30) begin
            z -= PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z += PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < N_ROT; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i);
                y = y + asr(x, i);
                z -= atab[i];
            end else begin
                nx = x + asr(y, i);
                y = y - asr(x, i);
                z += atab[i];
            end
            x = nx;
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    function automatic logic [23:0] axis_pos(logic [31:0] ctr, longint rad, longint f);
        longint p;
        p = asr(rad * f + (64'sd1 <<< 29), 30);
        return 24'(clip(sx(ctr, 24) + p, -8388608, 8388607));
    endfunction

    task automatic predict_eye(input cmd_t cmd, input logic [23:0] amt);
        longint      a, sa, ca, sp, cp, cpca, cpsa;
        eye_result_t r;
        a = sx(amt, 24);
        case (cmd)
            CMD_ROT_AZ: cam_az = wrap_angle(cam_az + a);
            CMD_ROT_POL: cam_pol = clip(cam_pol + a, -CAP_A, CAP_A);
            CMD_ZOOM: begin
                cam_rad = cam_rad - a;
                if (cam_rad > 8388607) cam_rad = 8388607;
                if (cam_rad < longint'(regs[REG_MIN_RADIUS])) cam_rad = regs[REG_MIN_RADIUS];
            end
            default: begin
                cam_az  = wrap_angle(regs[REG_START_AZ]);
                cam_pol = clip(sx(regs[REG_START_POLAR], 18), -CAP_A, CAP_A);
                cam_rad = regs[REG_START_RADIUS];
            end
        endcase
        rotate_sincos(cam_az, sa, ca);
        rotate_sincos(cam_pol, sp, cp);
        cpca = asr(cp * ca + (64'sd1 <<< 29), 30);
        cpsa = asr(cp * sa + (64'sd1 <<< 29), 30);
        r.eye_x   = axis_pos(regs[REG_CENTER_X], cam_rad, cpca);
        r.eye_y   = axis_pos(regs[REG_CENTER_Y], cam_rad, sp);
        r.eye_z   = axis_pos(regs[REG_CENTER_Z], cam_rad, cpsa);
        r.azimuth = 19'(cam_az);
        r.polar   = 18'(cam_pol);
        r.radius  = 23'(cam_rad);
        eye_queue.push_back(r);
    endtask

    task automatic send_command(input cmd_t cmd, input logic [23:0] amt);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= amt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_eye(cmd, amt);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (eye_queue.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: regs[idx] = 32'(val) & 32'hffffff;
            REG_MIN_RADIUS, REG_START_RADIUS: regs[idx] = 32'(val) & 32'h7fffff;
            REG_START_AZ: regs[idx] = 32'(val) & 32'h7ffff;
            default: regs[idx] = 32'(val) & 32'h3ffff;
        endcase
    endtask

    function automatic logic [23:0] rand_amount();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return 24'(sx($urandom_range(0, 16383), 15));
            2: return 24'(sx($urandom_range(0, 262143), 19));
            3: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            default: return 24'(sx($urandom_range(0, 4095), 12));
        endcase
    endfunction

    task automatic test_defaults();
        send_command(CMD_ZOOM, 24'd100);
        send_command(CMD_ROT_AZ, 24'd1000);
        send_command(CMD_RESTART, 24'd0);
        send_command(CMD_ROT_AZ, 24'h7fffff);
        send_command(CMD_ROT_AZ, 24'h800000);
        send_command(CMD_ROT_AZ, 24'(-1));
        send_command(CMD_ROT_AZ, 24'(TWO_PI_A));
        send_command(CMD_ROT_POL, 24'h7fffff);
        send_command(CMD_ROT_POL, 24'h800000);
        send_command(CMD_ROT_POL, 24'd102878);
        send_command(CMD_ZOOM, 24'h800000);
        send_command(CMD_ZOOM, 24'h7fffff);
        send_command(CMD_ZOOM, 24'(-1000));
        drain_results();
    endtask

    task automatic test_extreme_registers();
        write_reg(REG_CENTER_X, 8388607);
        write_reg(REG_CENTER_Y, -8388608);
        write_reg(REG_CENTER_Z, 8388607);
        write_reg(REG_MIN_RADIUS, 0);
        write_reg(REG_START_RADIUS, 8388607);
        write_reg(REG_START_AZ, 411774);
        write_reg(REG_START_POLAR, -102878);
        send_command(CMD_RESTART, 24'hffffff);
        send_command(CMD_ROT_POL, 24'd205756);
        send_command(CMD_ZOOM, 24'd8388607);
        send_command(CMD_ZOOM, 24'h800000);
        drain_results();
        // out-of-range start pose must be wrapped and clamped
        write_reg(REG_START_AZ, 524287);
        write_reg(REG_START_POLAR, 131071);
        write_reg(REG_START_RADIUS, 0);
        write_reg(REG_MIN_RADIUS, 8388607);
        send_command(CMD_RESTART, 24'd5);
        send_command(CMD_ZOOM, 24'd1);
        drain_results();
        write_reg(REG_START_POLAR, 0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 300 == 299) begin
                drain_results();
                for (int k = 0; k < 7; k++) begin
                    case (k)
                        REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z:
                            write_reg(3'(k), sx($urandom, $urandom_range(10, 24)));
                        REG_MIN_RADIUS: write_reg(3'(k), $urandom_range(0, 8192));
                        REG_START_RADIUS: write_reg(3'(k), $urandom_range(0, 8388607));
                        REG_START_AZ: write_reg(3'(k), $urandom_range(0, 524287));
                        default: write_reg(3'(k), $urandom_range(0, 262143));
                    endcase
                end
            end
            if (i == count - 200) calm = 1'b1;
            send_command(cmd_t'($urandom_range(0, 3)), rand_amount());
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        eye_result_t exp_r, got;
        if (m_tvalid && m_tready) begin
            got = eye_result_t'(m_tdata[131:0]);
            if (eye_queue.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected transaction %h", m_tdata);
            end else begin
                exp_r = eye_queue.pop_front();
                if (got !== exp_r || m_tdata[135:132] !== 4'd0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h az=%h pol=%h r=%h",
                            exp_r.eye_x, exp_r.eye_y, exp_r.eye_z, exp_r.azimuth,
                            exp_r.polar, exp_r.radius,
                            " | got x=%h y=%h z=%h az=%h pol=%h r=%h",
                            got.eye_x, got.eye_y, got.eye_z, got.azimuth,
                            got.polar, got.radius);
                end
            end
        end
    end

    // receiver stall bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // watchdog on accepted transactions
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("tb_orbit_camera_eye_position_core: FAIL");
                $finish;
            end
        end
    end

    initial begin
        regs = '{0, 0, 0, 256, 2560, 0, 0};
        cam_az = 0;
        cam_pol = 0;
        cam_rad = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_extreme_registers();
        test_random(1830);
        drain_results();
        if (n_err == 0)
            $display("tb_orbit_camera_eye_position_core: PASS");
        else
            $display("tb_orbit_camera_eye_position_core: FAIL");
        $finish;
    end

endmodule
